/* rtl/cpl_pkg.sv */
// Shared types and codes for the clamped piecewise linear lookup.
`timescale 1ns / 1ps
`default_nettype none
package cpl_pkg;
  localparam logic [1:0] OP_QUERY = 2'd0;
  localparam logic [1:0] OP_LOAD_DUR = 2'd1;
  localparam logic [1:0] OP_LOAD_VEL = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [2:0] REG_IFLOOR = 3'd0;
  localparam logic [2:0] REG_ICEIL = 3'd1;
  localparam logic [2:0] REG_DFLOOR = 3'd2;
  localparam logic [2:0] REG_DCEIL = 3'd3;
  localparam logic [2:0] REG_VFLOOR = 3'd4;
  localparam logic [2:0] REG_VCEIL = 3'd5;
  localparam logic [2:0] REG_DCOUNT = 3'd6;
  localparam logic [2:0] REG_VCOUNT = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_PICK, ST_DIV, ST_DONE
  } state_t;
endpackage
`default_nettype wire

/* rtl/cpl_cell.sv */
// One table cell: holds a point and passes the scan word to its neighbour.
`timescale 1ns / 1ps
`default_nettype none
module cpl_cell #(
  parameter int VW = 32
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [VW-1:0] wr_key,
  input  wire logic [VW-1:0] wr_val,
  input  wire logic          shift_en,
  input  wire logic [VW-1:0] prev_key,
  input  wire logic [VW-1:0] prev_val,
  output logic      [VW-1:0] key_r,
  output logic      [VW-1:0] val_r
);
  // shift mode rotates the table along the chain; head is read at cell 0
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_r <= wr_key;
      val_r <= wr_val;
    end else if (shift_en) begin
      key_r <= prev_key;
      val_r <= prev_val;
    end
  end
endmodule
`default_nettype wire

/* rtl/cpl_table.sv */
// Chain of cells for one table, with segment search and interpolation.
`timescale 1ns / 1ps
`default_nettype none
module cpl_table #(
  parameter int VW = 32,
  parameter int NP = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          wr_en,
  input  wire logic [4:0]    wr_idx,
  input  wire logic [VW-1:0] wr_key,
  input  wire logic [VW-1:0] wr_val,
  input  wire logic [5:0]    count,
  input  wire logic [VW-1:0] q,
  output logic               done,
  output logic      [VW-1:0] result
);
  import cpl_pkg::*;
  localparam int CW = $clog2(NP + 1);
  localparam int DCW = $clog2(2 * VW + 2);

  logic [VW-1:0] key [NP];
  logic [VW-1:0] val [NP];
  logic shift;
  state_t st_r, st_nxt;
  logic [CW-1:0] pos_r, n_r;
  logic signed [VW-1:0] pk_r, pv_r, k0_r, v0_r, kl_r, vl_r;
  logic signed [VW-1:0] lk_r, lv_r, rk_r, rv_r;
  logic found_r;
  logic [DCW-1:0] dc_r;
  logic [2*VW-1:0] dvd_r;
  logic [VW:0] den_r, rem_r;
  logic neg_r, rdy_r;
  logic signed [VW-1:0] res_r;
  logic direct;

  genvar g;
  generate
    for (g = 0; g < NP; g++) begin : g_cell
      cpl_cell #(.VW(VW)) u_cell (
        .clk(clk),
        .wr_en(wr_en && (32'(wr_idx) == g) && (st_r == ST_IDLE)),
        .wr_key(wr_key), .wr_val(wr_val), .shift_en(shift),
        .prev_key(key[(g + 1) % NP]), .prev_val(val[(g + 1) % NP]),
        .key_r(key[g]), .val_r(val[g])
      );
    end
  endgenerate

  logic [CW-1:0] n_eff;
  always_comb begin
    if (count == 6'd0) n_eff = CW'(1);
    else if (32'(count) > NP) n_eff = CW'(NP);
    else n_eff = CW'(count);
  end

  // a full rotation of the chain restores the table order
  assign shift = (st_r == ST_SCAN);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (start) st_nxt = ST_SCAN;
      ST_SCAN: if (32'(pos_r) == NP - 1) st_nxt = ST_PICK;
      ST_PICK: st_nxt = direct ? ST_DONE : ST_DIV;
      ST_DIV:  if (dc_r == DCW'(0)) st_nxt = ST_DONE;
      ST_DONE: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign done = (st_r == ST_DONE);
  // quotient is applied to the left value while in ST_DONE
  assign result = rdy_r ? res_r : (neg_r ? lv_r - dvd_r[VW-1:0] : lv_r + dvd_r[VW-1:0]);

  logic signed [VW-1:0] hk, hv;
  assign hk = key[0];
  assign hv = val[0];
  logic signed [VW:0] num, den, dy;
  logic [VW:0] dya;
  logic [VW:0] rem_sh;
  always_comb begin
    num = {lk_r[VW-1], lk_r};
    num = {q[VW-1], q} - num;
    den = {rk_r[VW-1], rk_r} - {lk_r[VW-1], lk_r};
    dy = {rv_r[VW-1], rv_r} - {lv_r[VW-1], lv_r};
    dya = dy[VW] ? (VW+1)'(-dy) : dy;
    if (num > den) num = den;
    rem_sh = {rem_r[VW-1:0], dvd_r[2*VW-1]};
  end

  assign direct = ($signed(q) <= k0_r) || ($signed(q) >= kl_r) || (den <= 0) || (num <= 0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    case (st_r)
      ST_IDLE: begin
        pos_r <= '0;
        n_r <= n_eff;
        found_r <= 1'b0;
        k0_r <= key[0];
        v0_r <= val[0];
        pk_r <= key[0];
        pv_r <= val[0];
        lk_r <= key[0];
        lv_r <= val[0];
        rk_r <= key[0];
        rv_r <= val[0];
      end
      ST_SCAN: begin
        // head cell holds entry pos_r; segment k is the first k<=n-2 with q<=x[k+1]
        if (pos_r == n_r - CW'(1)) begin
          kl_r <= hk;
          vl_r <= hv;
        end
        if (pos_r != '0 && !found_r && 32'(pos_r) <= 32'(n_r) - 1) begin
          lk_r <= pk_r; lv_r <= pv_r; rk_r <= hk; rv_r <= hv;
          if ($signed(q) <= hk || 32'(pos_r) == 32'(n_r) - 1) found_r <= 1'b1;
        end
        pk_r <= hk;
        pv_r <= hv;
        pos_r <= pos_r + CW'(1);
      end
      ST_PICK: begin
        rdy_r <= direct;
        if ($signed(q) <= k0_r) res_r <= v0_r;
        else if ($signed(q) >= kl_r) res_r <= vl_r;
        else if (den <= 0 || num <= 0) res_r <= lv_r;
        else begin
          res_r <= lv_r;
          dvd_r <= (2*VW)'(dya) * (2*VW)'(num[VW-1:0]);
          den_r <= den;
          neg_r <= dy[VW];
          rem_r <= '0;
          dc_r <= DCW'(2 * VW - 1);
        end
      end
      ST_DIV: begin
        // restoring division, one quotient bit a cycle
        if (rem_sh >= den_r) begin
          rem_r <= rem_sh - den_r;
          dvd_r <= {dvd_r[2*VW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          dvd_r <= {dvd_r[2*VW-2:0], 1'b0};
        end
        dc_r <= dc_r - DCW'(1);
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

/* rtl/clamped_piecewise_linear_lookup.sv */
// Top level: APB registers, stream handshake, clamping around two tables.
// A query's word is valid after a full rotation of each cell chain and, when a division
// is needed, a bit-serial divider; a load is written at its accepting edge.
// One word is in work at a time; input waits until the result word is taken.
// rst_n is synchronous: registers return to reset values, tables undefined.
`timescale 1ns / 1ps
`default_nettype none
module clamped_piecewise_linear_lookup #(
  parameter int MAX_POINTS = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // op, point_index, point_key, point_value, query_interval (low bit up)
  input  wire logic [((7+3*VALUE_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // duration_out, velocity_out (low bit up)
  output logic [((2*VALUE_WIDTH+7)/8)*8-1:0] out_tdata,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [4:0]                 cfg_paddr,
  input  wire logic [31:0]                cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);
  import cpl_pkg::*;
  localparam int VW = VALUE_WIDTH;
  localparam int OW = ((2*VW+7)/8)*8;

  logic signed [VW-1:0] ifl_r, ice_r, dfl_r, dce_r, vfl_r, vce_r;
  logic [5:0] dcn_r, vcn_r;
  logic [VW-1:0] cw;
  assign cw = VW'($signed(cfg_pwdata));
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ifl_r <= '0; ice_r <= {1'b0, {(VW-1){1'b1}}};
      dfl_r <= '0; dce_r <= {1'b0, {(VW-1){1'b1}}};
      vfl_r <= '0; vce_r <= {1'b0, {(VW-1){1'b1}}};
      dcn_r <= 6'd1; vcn_r <= 6'd1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[4:2])
        REG_IFLOOR: ifl_r <= cw;
        REG_ICEIL:  ice_r <= cw;
        REG_DFLOOR: dfl_r <= cw;
        REG_DCEIL:  dce_r <= cw;
        REG_VFLOOR: vfl_r <= cw;
        REG_VCEIL:  vce_r <= cw;
        REG_DCOUNT: dcn_r <= cfg_pwdata[5:0];
        REG_VCOUNT: vcn_r <= cfg_pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      REG_IFLOOR: cfg_prdata = 32'($signed(ifl_r));
      REG_ICEIL:  cfg_prdata = 32'($signed(ice_r));
      REG_DFLOOR: cfg_prdata = 32'($signed(dfl_r));
      REG_DCEIL:  cfg_prdata = 32'($signed(dce_r));
      REG_VFLOOR: cfg_prdata = 32'($signed(vfl_r));
      REG_VCEIL:  cfg_prdata = 32'($signed(vce_r));
      REG_DCOUNT: cfg_prdata = {26'd0, dcn_r};
      REG_VCOUNT: cfg_prdata = {26'd0, vcn_r};
      default:    cfg_prdata = '0;
    endcase
  end

  logic [1:0] op;
  logic [4:0] idx;
  logic signed [VW-1:0] pkey, pval, qin, qc;
  assign op = in_tdata[1:0];
  assign idx = in_tdata[6:2];
  assign pkey = in_tdata[7+VW-1:7];
  assign pval = in_tdata[7+2*VW-1:7+VW];
  assign qin = in_tdata[7+3*VW-1:7+2*VW];

  logic busy_r;
  logic dhave_r, vhave_r;
  logic signed [VW-1:0] q_r;
  logic acc, ddone, vdone;
  logic [VW-1:0] dres, vres;
  assign in_tready = !busy_r && !out_tvalid;
  assign acc = in_tvalid && in_tready;
  logic ld_ok;
  assign ld_ok = acc && (32'(idx) < MAX_POINTS);

  always_comb begin
    qc = qin;
    if (qc < ifl_r) qc = ifl_r;
    if (qc > ice_r) qc = ice_r;
  end

  always_ff @(posedge clk) if (acc) q_r <= qc;

  logic qstart_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; qstart_r <= 1'b0;
    end else begin
      qstart_r <= acc && (op == OP_QUERY);
      if (acc && op == OP_QUERY) busy_r <= 1'b1;
      else if ((ddone || dhave_r) && (vdone || vhave_r)) busy_r <= 1'b0;
    end
  end

  cpl_table #(.VW(VW), .NP(MAX_POINTS)) u_dur (
    .clk(clk), .rst_n(rst_n), .start(qstart_r),
    .wr_en(ld_ok && op == OP_LOAD_DUR), .wr_idx(idx), .wr_key(pkey), .wr_val(pval),
    .count(dcn_r), .q(q_r), .done(ddone), .result(dres)
  );
  cpl_table #(.VW(VW), .NP(MAX_POINTS)) u_vel (
    .clk(clk), .rst_n(rst_n), .start(qstart_r),
    .wr_en(ld_ok && op == OP_LOAD_VEL), .wr_idx(idx), .wr_key(pkey), .wr_val(pval),
    .count(vcn_r), .q(q_r), .done(vdone), .result(vres)
  );

  // the two tables may finish apart; hold the first result until the other is done
  logic signed [VW-1:0] dh_r, vh_r, dcl, vcl;
  always_comb begin
    dcl = dhave_r ? dh_r : $signed(dres);
    if (dcl < dfl_r) dcl = dfl_r;
    if (dcl > dce_r) dcl = dce_r;
    vcl = vhave_r ? vh_r : $signed(vres);
    if (vcl < vfl_r) vcl = vfl_r;
    if (vcl > vce_r) vcl = vce_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0; dhave_r <= 1'b0; vhave_r <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      if (ddone && !vdone) begin dhave_r <= 1'b1; dh_r <= dres; end
      if (vdone && !ddone) begin vhave_r <= 1'b1; vh_r <= vres; end
      if ((ddone || dhave_r) && (vdone || vhave_r)) begin
        out_tvalid <= 1'b1;
        out_tdata <= OW'({vcl, dcl});
        dhave_r <= 1'b0; vhave_r <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/cpl_checker.sv */
// Port-level checks for the lookup block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module cpl_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_tready,
  input wire logic out_tvalid,
  input wire logic out_tready,
  input wire logic cfg_pready
);
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result word dropped");
  a_noacc: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while result waits");
  a_pready: assert property (@(posedge clk) cfg_pready) else $error("pready low");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result after reset");
endmodule
bind clamped_piecewise_linear_lookup cpl_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .cfg_pready(cfg_pready)
);
`default_nettype wire
